>>> hdl/mgrs_pkg.sv
// ----------------------------------------------------------------------------
// Masked grid relaxation solver package
// Shared constants, command codes and the control struct between the
// sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package mgrs_pkg;

  localparam int unsigned DefMaxRows = 64;
  localparam int unsigned DefMaxCols = 64;
  localparam int unsigned DefValueWidth = 32;

  localparam int unsigned CmdWidth = 2;
  localparam logic [CmdWidth-1:0] CmdLoad = 2'd0;
  localparam logic [CmdWidth-1:0] CmdRun = 2'd1;
  localparam logic [CmdWidth-1:0] CmdRead = 2'd2;

  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam logic [CfgIdxWidth-1:0] RegWeight = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegXCoeff = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegYCoeff = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegTol = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegMaxSweeps = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegRows = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegCols = 3'd6;

  localparam int unsigned SumWidth = 128;

  typedef struct packed {
    logic sqrt_start;
  } mgrs_ctl_t;

endpackage

>>> hdl/masked_grid_relaxation_solver_unit.sv
// ----------------------------------------------------------------------------
// Masked grid relaxation solver
// In-place fixed point relaxation of a masked 2-D potential grid.
// ----------------------------------------------------------------------------
// Usage: configuration registers are written through cfg_we_i/cfg_idx_i/
// cfg_data_i while the block is idle. Items enter on the in channel
// (valid/ready) and results leave on the out channel (valid/ready).
// A load item writes one point and enable bit and gives no result. A read
// item yields one result. A run item sweeps the grid; a held point is
// passed over faster than an enabled one, since all grid traffic goes
// through two single port RAMs on one shared address and one shared
// multiplier that forms the six products one after another. After every
// sweep the RMS unit runs 128 divide steps, then 32 root steps.
// One result follows the run. The block takes one item at a time and is
// not ready until its result has been taken by the receiver, so a stalled
// receiver holds the block. Reset returns the sequencer to idle and the
// registers to their defaults; the grid contents are undefined until loaded.
// ----------------------------------------------------------------------------
module masked_grid_relaxation_solver_unit
  import mgrs_pkg::*;
#(
  parameter int unsigned MaxRows = DefMaxRows,
  parameter int unsigned MaxCols = DefMaxCols,
  parameter int unsigned ValueWidth = DefValueWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              command_i,
  input  logic [5:0]              row_index_i,
  input  logic [5:0]              col_index_i,
  input  logic signed [31:0]      point_value_i,
  input  logic                    update_enable_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    result_kind_o,
  output logic signed [31:0]      read_value_o,
  output logic [31:0]             rms_change_o,
  output logic [15:0]             sweeps_done_o,
  output logic                    converged_o
);

  localparam int unsigned Depth = MaxRows * MaxCols;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned RW = $clog2(MaxRows + 1);
  localparam int unsigned CW = $clog2(MaxCols + 1);
  localparam int unsigned VW = ValueWidth;
  localparam int unsigned AccW = VW + 24;
  localparam logic signed [AccW-1:0] VMax = AccW'((65'sd1 <<< (VW - 1)) - 1);
  localparam logic signed [AccW-1:0] VMin = -VMax - 1;
  localparam logic signed [AccW-1:0] RdMax = AccW'(64'sd2147483647);
  localparam logic signed [AccW-1:0] RdMin = -RdMax - 1;

  localparam logic [4:0] SIdle = 5'd0;
  localparam logic [4:0] SRdWait = 5'd1;
  localparam logic [4:0] SRdData = 5'd2;
  localparam logic [4:0] SSweep = 5'd3;
  localparam logic [4:0] SOld = 5'd4;
  localparam logic [4:0] SOldD = 5'd5;
  localparam logic [4:0] SNbr = 5'd6;
  localparam logic [4:0] SNbrD = 5'd7;
  localparam logic [4:0] SMul = 5'd8;
  localparam logic [4:0] SAvg = 5'd9;
  localparam logic [4:0] SMul2 = 5'd10;
  localparam logic [4:0] SNew = 5'd11;
  localparam logic [4:0] SSq = 5'd12;
  localparam logic [4:0] SWrite = 5'd13;
  localparam logic [4:0] SRms = 5'd14;
  localparam logic [4:0] SRmsW = 5'd15;
  localparam logic [4:0] SOut = 5'd16;
  localparam logic [4:0] SEn = 5'd17;

  logic [17:0] weight_q;
  logic [15:0] xc_q, yc_q, maxsw_q;
  logic [31:0] tol_q;
  logic [6:0] rowc_q, colc_q;

  logic [4:0] st_q, st_d;
  logic [RW-1:0] rows_q, ri_q;
  logic [CW-1:0] cols_q, ci_q;
  logic [2:0] k_q;
  logic signed [VW-1:0] old_q;
  logic signed [VW-1:0] nbr_q [4];
  logic signed [AccW-1:0] acc_q, avg_q;
  logic signed [AccW-1:0] prod_q;
  logic [SumWidth-1:0] sum_q;
  logic [32:0] change_q;
  logic [15:0] sweeps_q;
  logic conv_q;
  logic signed [31:0] rd_q;
  logic kind_q;

  logic ram_we, en_we;
  logic [AW-1:0] addr;
  logic [VW-1:0] wdata, rdata;
  logic en_wd, en_rd;
  mgrs_ctl_t ctl;
  logic rms_done;
  logic [32:0] rms_val;

  mgrs_ram #(.Width(VW), .Depth(Depth)) u_pot (
    .clk_i, .we_i(ram_we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata));
  mgrs_ram #(.Width(1), .Depth(Depth)) u_en (
    .clk_i, .we_i(en_we), .addr_i(addr), .wdata_i(en_wd), .rdata_o(en_rd));

  mgrs_rms u_rms (
    .clk_i, .rst_ni, .start_i(ctl.sqrt_start), .sum_i(sum_q),
    .count_i(21'(rows_q) * 21'(cols_q)), .done_o(rms_done), .rms_o(rms_val));

  function automatic logic [AW-1:0] mk_addr(logic [RW-1:0] r, logic [CW-1:0] c);
    return AW'(r * MaxCols + c);
  endfunction

  logic in_inside;
  logic signed [VW-1:0] ld_val;
  logic signed [63:0] ld_ext;
  assign in_inside = (32'(row_index_i) < MaxRows) && (32'(col_index_i) < MaxCols);
  assign ld_ext = 64'(point_value_i);
  assign ld_val = (ld_ext > 64'(VMax)) ? VW'(VMax) :
                  (ld_ext < 64'(VMin)) ? VW'(VMin) : VW'(ld_ext);

  // Neighbour order: up, down, left, right.
  logic nb_edge;
  logic [AW-1:0] nb_addr;
  always_comb begin
    nb_edge = 1'b0;
    nb_addr = '0;
    unique case (k_q[1:0])
      2'd0: begin
        nb_edge = ri_q == '0;
        nb_addr = mk_addr(ri_q - RW'(1), ci_q);
      end
      2'd1: begin
        nb_edge = ri_q == rows_q - RW'(1);
        nb_addr = mk_addr(ri_q + RW'(1), ci_q);
      end
      2'd2: begin
        nb_edge = ci_q == '0;
        nb_addr = mk_addr(ri_q, ci_q - CW'(1));
      end
      default: begin
        nb_edge = ci_q == cols_q - CW'(1);
        nb_addr = mk_addr(ri_q, ci_q + CW'(1));
      end
    endcase
  end

  // Shared multiplier operands.
  logic signed [VW-1:0] m_a;
  logic signed [18:0] m_b;
  always_comb begin
    m_a = old_q;
    m_b = 19'(weight_q);
    if (st_q == SMul) begin
      m_a = nbr_q[k_q[1:0]];
      m_b = k_q[1] ? 19'(yc_q) : 19'(xc_q);
    end else if (k_q[0]) begin
      m_a = VW'(avg_q);
      m_b = 19'sd65536 - 19'(weight_q);
    end
  end

  logic signed [AccW-1:0] rnd, sat_rnd, diff;
  logic [AccW-1:0] dmag;
  logic signed [AccW-1:0] rd_ext;
  assign rnd = (acc_q + AccW'(32768)) >>> 16;
  assign sat_rnd = rnd > VMax ? VMax : (rnd < VMin ? VMin : rnd);
  assign diff = avg_q - AccW'(old_q);
  assign dmag = diff[AccW-1] ? AccW'(-diff) : AccW'(diff);
  assign rd_ext = AccW'(signed'(rdata));

  logic last_pt;
  assign last_pt = (ri_q == rows_q - RW'(1)) && (ci_q == cols_q - CW'(1));

  always_comb begin
    st_d = st_q;
    ram_we = 1'b0;
    en_we = 1'b0;
    addr = mk_addr(ri_q, ci_q);
    wdata = VW'(avg_q);
    en_wd = update_enable_i;
    ctl = '0;
    in_ready_o = st_q == SIdle;
    unique case (st_q)
      SIdle: begin
        addr = AW'(row_index_i) * AW'(MaxCols) + AW'(col_index_i);
        wdata = ld_val;
        if (in_valid_i) begin
          unique case (command_i)
            CmdLoad: begin
              ram_we = in_inside;
              en_we = in_inside;
            end
            CmdRun: st_d = SSweep;
            CmdRead: st_d = SRdWait;
            default: st_d = SIdle;
          endcase
        end
      end
      SRdWait: st_d = SRdData;
      SRdData: st_d = SOut;
      SSweep: begin
        if (change_q <= 33'(tol_q)) begin
          st_d = SOut;
        end else if (sweeps_q >= maxsw_q) begin
          st_d = SOut;
        end else begin
          st_d = SEn;
        end
      end
      SEn: st_d = SOld;
      SOld: st_d = SOldD;
      SOldD: st_d = en_rd ? SNbr : (last_pt ? SRms : SEn);
      SNbr: begin
        addr = nb_addr;
        st_d = nb_edge ? (k_q == 3'd3 ? SMul : SNbr) : SNbrD;
      end
      SNbrD: st_d = k_q == 3'd3 ? SMul : SNbr;
      SMul: st_d = k_q == 3'd4 ? SAvg : SMul;
      SAvg: st_d = SMul2;
      SMul2: st_d = k_q == 3'd2 ? SNew : SMul2;
      SNew: st_d = SSq;
      SSq: st_d = SWrite;
      SWrite: begin
        ram_we = 1'b1;
        st_d = last_pt ? SRms : SEn;
      end
      SRms: begin
        ctl.sqrt_start = 1'b1;
        st_d = SRmsW;
      end
      SRmsW: st_d = rms_done ? SSweep : SRmsW;
      SOut: st_d = out_ready_i ? SIdle : SOut;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      weight_q <= 18'd32768;
      xc_q <= 16'd16384;
      yc_q <= 16'd16384;
      tol_q <= 32'd66;
      maxsw_q <= 16'd1000;
      rowc_q <= 7'd64;
      colc_q <= 7'd64;
      k_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegWeight: weight_q <= cfg_data_i[17:0];
          RegXCoeff: xc_q <= cfg_data_i[15:0];
          RegYCoeff: yc_q <= cfg_data_i[15:0];
          RegTol: tol_q <= cfg_data_i;
          RegMaxSweeps: maxsw_q <= cfg_data_i[15:0];
          RegRows: rowc_q <= cfg_data_i[6:0];
          RegCols: colc_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      unique case (st_q)
        SNbr, SNbrD: begin
          if (st_q == SNbrD || nb_edge) begin
            k_q <= k_q == 3'd3 ? 3'd0 : k_q + 3'd1;
          end
        end
        SMul: k_q <= k_q == 3'd4 ? 3'd0 : k_q + 3'd1;
        SMul2: k_q <= k_q == 3'd2 ? 3'd0 : k_q + 3'd1;
        default: k_q <= '0;
      endcase
    end
  end

  logic [31:0] rows_c, cols_c;
  assign rows_c = rowc_q == 0 ? 32'd1 : (32'(rowc_q) > MaxRows ? MaxRows : 32'(rowc_q));
  assign cols_c = colc_q == 0 ? 32'd1 : (32'(colc_q) > MaxCols ? MaxCols : 32'(colc_q));

  always_ff @(posedge clk_i) begin
    prod_q <= AccW'(m_a * m_b);
    unique case (st_q)
      SIdle: begin
        rows_q <= RW'(rows_c);
        cols_q <= CW'(cols_c);
        change_q <= {tol_q, 1'b0};
        sweeps_q <= '0;
        conv_q <= 1'b1;
        kind_q <= command_i == CmdRun;
        rd_q <= '0;
        ri_q <= in_inside ? RW'(row_index_i) : '0;
        ci_q <= in_inside ? CW'(col_index_i) : '0;
        acc_q <= '0;
        avg_q <= AccW'(in_inside);
      end
      SRdData: begin
        rd_q <= avg_q[0] ? ((rd_ext > RdMax) ? 32'sh7fffffff :
                (rd_ext < RdMin ? 32'sh80000000 : 32'(rd_ext))) : '0;
      end
      SSweep: begin
        ri_q <= '0;
        ci_q <= '0;
        sum_q <= '0;
        if (change_q > 33'(tol_q) && sweeps_q >= maxsw_q) begin
          conv_q <= 1'b0;
        end
      end
      SOldD: begin
        old_q <= signed'(rdata);
        acc_q <= '0;
        if (!en_rd && !last_pt) begin
          if (ci_q == cols_q - CW'(1)) begin
            ci_q <= '0;
            ri_q <= ri_q + RW'(1);
          end else begin
            ci_q <= ci_q + CW'(1);
          end
        end
      end
      SNbr: if (nb_edge) nbr_q[k_q[1:0]] <= old_q;
      SNbrD: nbr_q[k_q[1:0]] <= signed'(rdata);
      SMul: if (k_q != 3'd0) acc_q <= acc_q + prod_q;
      SAvg: begin
        avg_q <= sat_rnd;
        acc_q <= '0;
      end
      SMul2: if (k_q != 3'd0) acc_q <= acc_q + prod_q;
      SNew: avg_q <= sat_rnd;
      SSq: sum_q <= sum_q + SumWidth'(dmag[VW-1:0] * dmag[VW-1:0]);
      SWrite: begin
        if (!last_pt) begin
          if (ci_q == cols_q - CW'(1)) begin
            ci_q <= '0;
            ri_q <= ri_q + RW'(1);
          end else begin
            ci_q <= ci_q + CW'(1);
          end
        end
      end
      SRmsW: begin
        if (rms_done) begin
          change_q <= rms_val;
          sweeps_q <= sweeps_q + 16'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = st_q == SOut;
  assign result_kind_o = kind_q;
  assign read_value_o = kind_q ? '0 : rd_q;
  assign rms_change_o = kind_q ? (change_q[32] ? 32'hFFFF_FFFF : change_q[31:0]) : '0;
  assign sweeps_done_o = kind_q ? sweeps_q : '0;
  assign converged_o = kind_q ? conv_q : 1'b0;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_write_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && st_q != SIdle |-> st_q == SWrite) else $error("stray grid write");
  a_rms_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.sqrt_start |=> st_q == SRmsW) else $error("rms start not followed");
`endif

endmodule

>>> hdl/mgrs_ram.sv
// ----------------------------------------------------------------------------
// Generic single port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mgrs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> hdl/mgrs_rms.sv
// ----------------------------------------------------------------------------
// RMS unit
// Divides the sum of squared changes by the point count with a restoring
// divider, one quotient bit per cycle, then takes a bit-serial square root.
// ----------------------------------------------------------------------------
module mgrs_rms (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mgrs_pkg::SumWidth-1:0] sum_i,
  input  logic [20:0]                  count_i,
  output logic                         done_o,
  output logic [32:0]                  rms_o
);
  import mgrs_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv = 2'd1;
  localparam logic [1:0] StSqrt = 2'd2;

  logic [1:0] st_q, st_d;
  logic [6:0] cnt_q, cnt_d;
  logic [SumWidth-1:0] num_q, num_d;
  logic [21:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] root_q, root_d;
  logic [65:0] srem_q, srem_d;
  logic big_q, big_d;
  logic [21:0] rem_sh;
  logic [65:0] s_try, s_sh;

  assign rem_sh = {rem_q[20:0], num_q[SumWidth-1]};
  assign s_sh = {srem_q[63:0], quo_q[63:62]};
  assign s_try = s_sh - {31'd0, root_q, 2'b01};

  always_comb begin
    st_d = st_q;
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    quo_d = quo_q;
    root_d = root_q;
    srem_d = srem_q;
    big_d = big_q;
    done_o = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          st_d = StDiv;
          num_d = sum_i;
          rem_d = '0;
          quo_d = '0;
          big_d = 1'b0;
          cnt_d = '0;
        end
      end
      StDiv: begin
        num_d = {num_q[SumWidth-2:0], 1'b0};
        quo_d = {quo_q[62:0], 1'b0};
        if (quo_q[63]) begin
          big_d = 1'b1;
        end
        if (rem_sh >= {1'b0, count_i}) begin
          rem_d = rem_sh - {1'b0, count_i};
          quo_d[0] = 1'b1;
        end else begin
          rem_d = rem_sh;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          st_d = StSqrt;
          root_d = '0;
          srem_d = '0;
          cnt_d = '0;
        end
      end
      StSqrt: begin
        quo_d = {quo_q[61:0], 2'b00};
        if (!s_try[65]) begin
          srem_d = s_try;
          root_d = {root_q[31:0], 1'b1};
        end else begin
          srem_d = s_sh;
          root_d = {root_q[31:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd31) begin
          st_d = StIdle;
          done_o = 1'b1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  assign rms_o = big_q ? 33'h1_0000_0000 : root_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    root_q <= root_d;
    srem_q <= srem_d;
    big_q <= big_d;
  end

`ifndef SYNTHESIS
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && st_q == StIdle |=> st_q == StDiv) else $error("rms start lost");
  a_done_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> st_q == StSqrt) else $error("rms done outside root phase");
  a_no_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StDiv |-> count_i != '0) else $error("rms divide by zero");
`endif

endmodule

>>> test/relaxation_checker.sv
// ----------------------------------------------------------------------------
// Relaxation solver checker
// Watches the register port and both item channels, keeps its own copy of the
// grid and registers, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module relaxation_checker
  import mgrs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [1:0]              command_i,
  input  logic [5:0]              row_index_i,
  input  logic [5:0]              col_index_i,
  input  logic signed [31:0]      point_value_i,
  input  logic                    update_enable_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic                    result_kind_i,
  input  logic signed [31:0]      read_value_i,
  input  logic [31:0]             rms_change_i,
  input  logic [15:0]             sweeps_done_i,
  input  logic                    converged_i,
  output int                      mismatches_o,
  output int                      pending_o,
  output int                      reads_seen_o,
  output int                      runs_seen_o
);

  localparam longint ValMax = 64'sd2147483647;
  localparam longint ValMin = -64'sd2147483648;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic [31:0] rms;
    logic [15:0] sweeps;
    logic        conv;
  } outcome_t;

  outcome_t    awaited[$];
  longint      potential[4096];
  bit          enabled[4096];
  logic [17:0] weight;
  logic [15:0] x_coeff;
  logic [15:0] y_coeff;
  logic [31:0] tolerance;
  logic [15:0] sweep_limit;
  logic [6:0]  row_cfg;
  logic [6:0]  col_cfg;

  function automatic longint round_q16(longint s);
    return (s + 64'sd32768) >>> 16;
  endfunction

  function automatic longint sat_value(longint x);
    if (x > ValMax) return ValMax;
    if (x < ValMin) return ValMin;
    return x;
  endfunction

  function automatic int clamp_dim(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] probe;
    res = '0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= res + probe) begin
        x = x - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // Sweeps the grid in place until the RMS change drops to the tolerance or
  // the sweep limit is hit.
  function automatic outcome_t relax_grid();
    int          rows;
    int          cols;
    int          idx;
    int          sweeps;
    logic        conv;
    logic [63:0] change;
    logic [127:0] sq_sum;
    logic [127:0] quot;
    longint      old, up, dn, lf, rt, avg, nv, d;
    logic [63:0] mag;
    outcome_t    o;
    rows = clamp_dim(row_cfg);
    cols = clamp_dim(col_cfg);
    change = {31'b0, tolerance, 1'b0};
    sweeps = 0;
    conv = 1'b1;
    while (change > {32'b0, tolerance}) begin
      if (sweeps >= sweep_limit) begin
        conv = 1'b0;
        break;
      end
      sq_sum = '0;
      for (int i = 0; i < rows; i++) begin
        for (int j = 0; j < cols; j++) begin
          idx = i * 64 + j;
          if (!enabled[idx]) continue;
          old = potential[idx];
          up = (i == 0) ? old : potential[idx - 64];
          dn = (i == rows - 1) ? old : potential[idx + 64];
          lf = (j == 0) ? old : potential[idx - 1];
          rt = (j == cols - 1) ? old : potential[idx + 1];
          avg = sat_value(round_q16(longint'(x_coeff) * (up + dn) +
                                    longint'(y_coeff) * (lf + rt)));
          nv = sat_value(round_q16(old * longint'(weight) +
                                   avg * (64'sd65536 - longint'(weight))));
          potential[idx] = nv;
          d = nv - old;
          mag = (d < 0) ? 64'(-d) : 64'(d);
          sq_sum = sq_sum + {64'b0, mag} * {64'b0, mag};
        end
      end
      quot = sq_sum / 128'(rows * cols);
      change = (quot[127:64] != 0) ? 64'h1_0000_0000 : floor_sqrt(quot[63:0]);
      sweeps++;
    end
    o = '0;
    o.kind = 1'b1;
    o.rms = (change > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : change[31:0];
    o.sweeps = sweeps[15:0];
    o.conv = conv;
    return o;
  endfunction

  function automatic void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
    mismatches_o++;
    if (mismatches_o <= 10)
      $display("Mismatch on %s: expected %h, got %h", what, exp_v, act_v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t o;
    int       idx;
    if (!rst_ni) begin
      awaited.delete();
      weight <= 18'd32768;
      x_coeff <= 16'd16384;
      y_coeff <= 16'd16384;
      tolerance <= 32'd66;
      sweep_limit <= 16'd1000;
      row_cfg <= 7'd64;
      col_cfg <= 7'd64;
      mismatches_o <= 0;
      pending_o <= 0;
      reads_seen_o <= 0;
      runs_seen_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegWeight:    weight <= cfg_data_i[17:0];
          RegXCoeff:    x_coeff <= cfg_data_i[15:0];
          RegYCoeff:    y_coeff <= cfg_data_i[15:0];
          RegTol:       tolerance <= cfg_data_i;
          RegMaxSweeps: sweep_limit <= cfg_data_i[15:0];
          RegRows:      row_cfg <= cfg_data_i[6:0];
          RegCols:      col_cfg <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited.size() == 0) begin
          report("unexpected item kind", 32'hx, {31'b0, result_kind_i});
        end else begin
          o = awaited.pop_front();
          if (o.kind) runs_seen_o <= runs_seen_o + 1;
          else reads_seen_o <= reads_seen_o + 1;
          if (result_kind_i !== o.kind) report("result_kind", o.kind, result_kind_i);
          if (read_value_i !== o.value) report("read_value", o.value, read_value_i);
          if (rms_change_i !== o.rms) report("rms_change", o.rms, rms_change_i);
          if (sweeps_done_i !== o.sweeps) report("sweeps_done", o.sweeps, sweeps_done_i);
          if (converged_i !== o.conv) report("converged", o.conv, converged_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        idx = int'(row_index_i) * 64 + int'(col_index_i);
        case (command_i)
          CmdLoad: begin
            potential[idx] = longint'(point_value_i);
            enabled[idx] = update_enable_i;
          end
          CmdRun: awaited.push_back(relax_grid());
          CmdRead: begin
            o = '0;
            o.value = potential[idx][31:0];
            awaited.push_back(o);
          end
          default: ;
        endcase
      end
      pending_o <= awaited.size();
    end
  end

endmodule

>>> test/tb_masked_grid_relaxation_solver_unit.sv
// ----------------------------------------------------------------------------
// Masked grid relaxation solver testbench
// Loads grids, runs relaxations and reads points back under many register
// settings with random idling on both channels; a separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_masked_grid_relaxation_solver_unit;
  import mgrs_pkg::*;

  localparam logic [1:0] CmdSpare = 2'd3;
  localparam int CycleLimit = 4000000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              command_i = CmdLoad;
  logic [5:0]              row_index_i = '0;
  logic [5:0]              col_index_i = '0;
  logic signed [31:0]      point_value_i = '0;
  logic                    update_enable_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    result_kind_o;
  logic signed [31:0]      read_value_o;
  logic [31:0]             rms_change_o;
  logic [15:0]             sweeps_done_o;
  logic                    converged_o;

  int mismatches, pending, reads_seen, runs_seen;
  int sent_items = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int written[$];

  always #6 clk_i = ~clk_i;

  masked_grid_relaxation_solver_unit dut (.*);

  relaxation_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .command_i, .row_index_i, .col_index_i,
    .point_value_i, .update_enable_i,
    .out_valid_i(out_valid_o), .out_ready_i, .result_kind_i(result_kind_o),
    .read_value_i(read_value_o), .rms_change_i(rms_change_o),
    .sweeps_done_i(sweeps_done_o), .converged_i(converged_o),
    .mismatches_o(mismatches), .pending_o(pending),
    .reads_seen_o(reads_seen), .runs_seen_o(runs_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver stalls in short bursts and once for a long stretch.
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!held && sent_items >= 300) begin
        held = 1'b1;
        stall_left = 499;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 1 << 20) - (1 << 19);
    endcase
  endfunction

  task automatic send_item(logic [1:0] cmd, int row, int col, logic [31:0] val, logic en);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    row_index_i <= row[5:0];
    col_index_i <= col[5:0];
    point_value_i <= val;
    update_enable_i <= en;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    sent_items++;
    if (cmd == CmdLoad) written.push_back(row * 64 + col);
  endtask

  task automatic read_written();
    int a;
    a = written[$urandom_range(0, written.size() - 1)];
    send_item(CmdRead, a / 64, a % 64, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic set_registers(int rows, int cols, int w, int xc, int yc,
                               logic [31:0] tol, int ms);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegWeight;    cfg_data_i <= w;    @(posedge clk_i);
    cfg_idx_i <= RegXCoeff;    cfg_data_i <= xc;   @(posedge clk_i);
    cfg_idx_i <= RegYCoeff;    cfg_data_i <= yc;   @(posedge clk_i);
    cfg_idx_i <= RegTol;       cfg_data_i <= tol;  @(posedge clk_i);
    cfg_idx_i <= RegMaxSweeps; cfg_data_i <= ms;   @(posedge clk_i);
    cfg_idx_i <= RegRows;      cfg_data_i <= rows; @(posedge clk_i);
    cfg_idx_i <= RegCols;      cfg_data_i <= cols; @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int rows, int cols, int w, int xc, int yc,
                           logic [31:0] tol, int ms, int nrand);
    int ar, ac, sel;
    set_registers(rows, cols, w, xc, yc, tol, ms);
    ar = (rows == 0) ? 1 : (rows > 64 ? 64 : rows);
    ac = (cols == 0) ? 1 : (cols > 64 ? 64 : cols);
    for (int i = 0; i < ar; i++)
      for (int j = 0; j < ac; j++)
        send_item(CmdLoad, i, j, pick_value(), $urandom_range(0, 3) != 0);
    for (int n = 0; n < nrand; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55)
        send_item(CmdLoad, $urandom_range(0, ar - 1), $urandom_range(0, ac - 1),
                  pick_value(), $urandom_range(0, 3) != 0);
      else if (sel < 65)
        send_item(CmdLoad, $urandom_range(0, 63), $urandom_range(0, 63),
                  pick_value(), 1'($urandom_range(0, 1)));
      else if (sel < 88)
        read_written();
      else if (sel < 93)
        send_item(CmdRun, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, 1'b0);
      else
        send_item(CmdSpare, $urandom_range(0, 63), $urandom_range(0, 63), $urandom,
                  1'($urandom_range(0, 1)));
    end
    send_item(CmdRun, 0, 0, 32'h0, 1'b0);
    read_written();
    read_written();
  endtask

  initial begin
    logic [31:0] tol;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_registers(2, 2, 32768, 16384, 16384, 32'd66, 5);
    send_item(CmdLoad, 0, 0, 32'h7FFF_FFFF, 1'b1);
    send_item(CmdLoad, 0, 1, 32'h8000_0000, 1'b1);
    send_item(CmdLoad, 1, 0, 32'h0000_0000, 1'b0);
    send_item(CmdLoad, 1, 1, 32'h0001_0000, 1'b1);
    send_item(CmdLoad, 63, 63, 32'hFFFF_FFFF, 1'b1);
    send_item(CmdRead, 0, 0, 32'h0, 1'b0);
    send_item(CmdRead, 0, 1, 32'h0, 1'b0);
    send_item(CmdRead, 63, 63, 32'h0, 1'b0);
    send_item(CmdSpare, 63, 63, 32'hFFFF_FFFF, 1'b1);
    send_item(CmdRun, 0, 0, 32'h0, 1'b0);
    for (int k = 0; k < 4; k++) send_item(CmdRead, k / 2, k % 2, 32'h0, 1'b0);

    run_phase(0, 0, 131072, 32768, 0, 32'd0, 7, 4);
    run_phase(3, 2, 0, 0, 32768, 32'hFFFF_FFFF, 0, 4);
    run_phase(1, 64, 0, 16384, 16384, 32'hFFFF_FFFF, 65535, 4);
    run_phase(127, 1, 65536, 32768, 32768, 32'd1, 3, 4);

    for (int p = 0; p < 20; p++) begin
      case ($urandom_range(0, 2))
        0: tol = 32'd0;
        1: tol = $urandom_range(0, 200);
        default: tol = $urandom;
      endcase
      quiet = (p >= 18);
      run_phase($urandom_range(1, 6), $urandom_range(1, 6),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131072)
                                            : $urandom_range(16384, 65536),
                $urandom_range(0, 32768), $urandom_range(0, 32768), tol,
                $urandom_range(0, 8), 58);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d items: %0d point reads and %0d relaxation runs were checked,",
             sent_items, reads_seen, runs_seen);
    $display("over grids from 1x1 up to 64 rows or columns and the register extremes.");
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
